[rtl/wwgs_pkg.sv]
// Package: shared widths, codes and control types of the gather/scatter unit.
`default_nettype none

package wwgs_pkg;

  localparam int GRID_DEPTH  = 4096;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int GRID_SIZE_W = 13;
  localparam int TAPS_W      = 6;
  localparam int TAP_IDX_W   = 5;
  localparam int DATA_W      = 24;
  localparam int WEIGHT_W    = 18;
  localparam int PROD_W      = DATA_W + WEIGHT_W;
  localparam int SUM_W       = 48;
  localparam int RND_SHIFT   = 16;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST   = GRID_SIZE_W'(4096);
  localparam logic [TAPS_W-1:0]      WINDOW_TAPS_RST = TAPS_W'(8);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_FWD   = 2'd1,
    REQ_ADJ   = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    REG_GRID_SIZE   = 1'b0,
    REG_WINDOW_TAPS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MOD  = 2'd1,
    S_READ = 2'd2,
    S_ACC  = 2'd3
  } state_e;

  typedef struct packed {
    logic mul;       // grid data valid: form product
    logic acc;       // accumulate or build write-back value
    logic adjoint;   // scatter-add request
    logic read_out;  // plain grid read
    logic last_tap;  // last tap of the node window
  } arith_ctrl_t;

endpackage

`default_nettype wire

[rtl/wwgs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module wwgs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/wwgs_wrap.sv]
// Bit-serial remainder unit: wraps a grid index by the configured grid size.
`default_nettype none

module wwgs_wrap
  import wwgs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [GRID_SIZE_W-1:0] dividend_i,
  input  wire logic [GRID_SIZE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic      [ADDR_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(GRID_SIZE_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GRID_SIZE_W - 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [GRID_SIZE_W-1:0] shift_q, shift_d;
  logic [GRID_SIZE_W-1:0] div_q, div_d;
  logic [ADDR_W-1:0]      rem_q, rem_d;
  logic [GRID_SIZE_W-1:0] trial;

  // remainder stays below divisor (at most GRID_DEPTH), so ADDR_W bits hold it
  assign trial = {rem_q, shift_q[GRID_SIZE_W-1]};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = LAST_CNT;
      shift_d = dividend_i;
      div_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      shift_d = {shift_q[GRID_SIZE_W-2:0], 1'b0};
      rem_d   = (trial >= div_q) ? ADDR_W'(trial - div_q) : ADDR_W'(trial);
      cnt_d   = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[rtl/wwgs_arith.sv]
// Arithmetic: tap product, saturating complex sum, rounded scatter-add, result register.
`default_nettype none

module wwgs_arith
  import wwgs_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire arith_ctrl_t                ctrl_i,
  input  wire logic signed [DATA_W-1:0]   grid_re_i,
  input  wire logic signed [DATA_W-1:0]   grid_im_i,
  input  wire logic signed [DATA_W-1:0]   node_re_i,
  input  wire logic signed [DATA_W-1:0]   node_im_i,
  input  wire logic signed [WEIGHT_W-1:0] weight_i,
  output logic signed      [DATA_W-1:0]   wb_re_o,
  output logic signed      [DATA_W-1:0]   wb_im_o,
  output logic                            res_valid_o,
  output logic signed      [SUM_W-1:0]    res_re_o,
  output logic signed      [SUM_W-1:0]    res_im_o,
  output logic                            res_kind_o
);

  localparam int RND_W = PROD_W + 1;
  localparam int QW    = RND_W - RND_SHIFT;
  localparam int ADD_W = QW + 1;
  localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [DATA_W-1:0] gdat_re_q, gdat_im_q;
  logic signed [SUM_W-1:0]  sum_re_q, sum_re_d, sum_im_q, sum_im_d;
  logic signed [SUM_W:0]    acc_re, acc_im;
  logic signed [RND_W-1:0]  rnd_re, rnd_im;
  logic signed [ADD_W-1:0]  add_re, add_im;
  logic                     valid_q, valid_d, kind_q;
  logic signed [SUM_W-1:0]  res_re_q, res_im_q;
  logic                     emit;

  // saturating complex sum
  assign acc_re = (SUM_W+1)'(sum_re_q) + (SUM_W+1)'(prod_re_q);
  assign acc_im = (SUM_W+1)'(sum_im_q) + (SUM_W+1)'(prod_im_q);

  always_comb begin
    sum_re_d = acc_re[SUM_W-1:0];
    sum_im_d = acc_im[SUM_W-1:0];
    if (acc_re[SUM_W] != acc_re[SUM_W-1]) begin
      sum_re_d = acc_re[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    if (acc_im[SUM_W] != acc_im[SUM_W-1]) begin
      sum_im_d = acc_im[SUM_W] ? SUM_MIN : SUM_MAX;
    end
  end

  // round to nearest, ties up: add half an lsb, then floor shift
  assign rnd_re = RND_W'(prod_re_q) + HALF_LSB;
  assign rnd_im = RND_W'(prod_im_q) + HALF_LSB;
  assign add_re = ADD_W'(gdat_re_q) + ADD_W'($signed(rnd_re[RND_W-1:RND_SHIFT]));
  assign add_im = ADD_W'(gdat_im_q) + ADD_W'($signed(rnd_im[RND_W-1:RND_SHIFT]));

  always_comb begin
    if (add_re > ADD_W'(DAT_MAX)) begin
      wb_re_o = DAT_MAX;
    end else if (add_re < ADD_W'(DAT_MIN)) begin
      wb_re_o = DAT_MIN;
    end else begin
      wb_re_o = add_re[DATA_W-1:0];
    end
    if (add_im > ADD_W'(DAT_MAX)) begin
      wb_im_o = DAT_MAX;
    end else if (add_im < ADD_W'(DAT_MIN)) begin
      wb_im_o = DAT_MIN;
    end else begin
      wb_im_o = add_im[DATA_W-1:0];
    end
  end

  assign emit    = ctrl_i.acc && !ctrl_i.adjoint && ctrl_i.last_tap;
  assign valid_d = (ctrl_i.mul && ctrl_i.read_out) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      sum_re_q <= '0;
      sum_im_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.acc && !ctrl_i.adjoint) begin
        sum_re_q <= ctrl_i.last_tap ? '0 : sum_re_d;
        sum_im_q <= ctrl_i.last_tap ? '0 : sum_im_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_re_q <= (ctrl_i.adjoint ? node_re_i : grid_re_i) * weight_i;
      prod_im_q <= (ctrl_i.adjoint ? node_im_i : grid_im_i) * weight_i;
      gdat_re_q <= grid_re_i;
      gdat_im_q <= grid_im_i;
    end
    if (ctrl_i.mul && ctrl_i.read_out) begin
      res_re_q <= SUM_W'(grid_re_i);
      res_im_q <= SUM_W'(grid_im_i);
      kind_q   <= 1'b1;
    end else if (emit) begin
      res_re_q <= sum_re_d;
      res_im_q <= sum_im_d;
      kind_q   <= 1'b0;
    end
  end

  assign res_valid_o = valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign res_kind_o  = kind_q;

endmodule

`default_nettype wire

[rtl/wrapped_window_gather_scatter_unit.sv]
// Top level: grid memory, request sequencer, APB registers of the gather/scatter unit.
`default_nettype none

// Usage
// Request channel: start_i with the request fields, taken at a clock edge where
// start_i is high and busy_o is low. req_type_i selects grid write, forward tap,
// adjoint tap or grid read.
// Result channel: result_valid_o strobes for one cycle with result_re_o,
// result_im_o and result_kind_o; there is no back-pressure, the receiver must
// take it in that cycle. Only grid reads and the last tap of a forward window
// produce a result.
// Request sequence (one grid memory port pair serves every request):
//   grid write        written at the accepting edge, the unit stays idle
//   grid read         read at acceptance, result strobe registered from S_READ
//   forward / adjoint S_READ, S_ACC if window_start + tap_index < 2 * wrap length;
//                     otherwise S_MOD first, the wrap going through the bit-serial
//                     remainder unit (13 steps). Forward result strobe is
//                     registered from S_ACC.
// Reset clears the sequencer, the running sum, the result strobe, and sets
// grid_size to 4096 and window_taps to 8. Grid contents are undefined until
// written; zero the grid by writes before an adjoint pass.
// Registers (APB, byte address): 0x0 grid_size, 0x4 window_taps. Write only
// while idle.

module wrapped_window_gather_scatter_unit
  import wwgs_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [ADDR_W-1:0]          grid_addr_i,
  input  wire logic signed [DATA_W-1:0]   data_re_i,
  input  wire logic signed [DATA_W-1:0]   data_im_i,
  input  wire logic [ADDR_W-1:0]          window_start_i,
  input  wire logic [TAP_IDX_W-1:0]       tap_index_i,
  input  wire logic signed [WEIGHT_W-1:0] weight_i,
  output logic                            result_valid_o,
  output logic signed [SUM_W-1:0]         result_re_o,
  output logic signed [SUM_W-1:0]         result_im_o,
  output logic                            result_kind_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_AW-1:0]          paddr,
  input  wire logic [APB_DW-1:0]          pwdata,
  output logic      [APB_DW-1:0]          prdata,
  output logic                            pready
);

  localparam int RAM_W = 2 * DATA_W;
  localparam logic [GRID_SIZE_W-1:0] DEPTH_N = GRID_SIZE_W'(GRID_DEPTH);

  // config registers
  logic [GRID_SIZE_W-1:0] grid_size_q;
  logic [TAPS_W-1:0]      window_taps_q;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;

  // sequencer
  state_e                 state_q, state_d;
  logic                   accept;
  req_e                   req_in;
  req_e                   req_q;
  logic signed [DATA_W-1:0]   node_re_q, node_im_q;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic [TAP_IDX_W-1:0]   tap_q;
  logic [ADDR_W-1:0]      idx_q;

  // wrap path
  logic [GRID_SIZE_W-1:0] n_eff, tap_sum, tap_sub;
  logic                   fast_lo, fast_hi, fast_ok;
  logic [ADDR_W-1:0]      fast_idx;
  logic                   wrap_start, wrap_done;
  logic [ADDR_W-1:0]      wrap_rem;

  // memory and datapath
  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [RAM_W-1:0]       ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] wb_re, wb_im;
  arith_ctrl_t            ctrl;

  // ---------------- APB registers ----------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= GRID_SIZE_RST;
      window_taps_q <= WINDOW_TAPS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRID_SIZE:   grid_size_q   <= pwdata[GRID_SIZE_W-1:0];
        REG_WINDOW_TAPS: window_taps_q <= pwdata[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRID_SIZE:   prdata = APB_DW'(grid_size_q);
      REG_WINDOW_TAPS: prdata = APB_DW'(window_taps_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- index wrap ----------------
  // zero or oversize grid_size falls back to the full depth
  assign n_eff    = (grid_size_q == '0 || grid_size_q > DEPTH_N) ? DEPTH_N : grid_size_q;
  assign tap_sum  = GRID_SIZE_W'(window_start_i) + GRID_SIZE_W'(tap_index_i);
  assign tap_sub  = tap_sum - n_eff;
  assign fast_lo  = tap_sum < n_eff;
  assign fast_hi  = {1'b0, tap_sum} < {n_eff, 1'b0};
  assign fast_ok  = fast_lo || fast_hi;
  assign fast_idx = fast_lo ? tap_sum[ADDR_W-1:0] : tap_sub[ADDR_W-1:0];

  wwgs_wrap u_wrap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (wrap_start),
    .dividend_i (tap_sum),
    .divisor_i  (n_eff),
    .done_o     (wrap_done),
    .rem_o      (wrap_rem)
  );

  // ---------------- sequencer ----------------
  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign req_in = req_e'(req_type_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_in)
            REQ_WRITE:        state_d = S_IDLE;
            REQ_READ:         state_d = S_READ;
            REQ_FWD, REQ_ADJ: state_d = fast_ok ? S_READ : S_MOD;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        if (wrap_done) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = (req_q == REQ_READ) ? S_IDLE : S_ACC;
      S_ACC:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = {wb_im, wb_re};
    ram_re        = 1'b0;
    ram_raddr     = fast_idx;
    wrap_start    = 1'b0;
    ctrl          = '0;
    ctrl.adjoint  = (req_q == REQ_ADJ);
    ctrl.read_out = (req_q == REQ_READ);
    ctrl.last_tap = (TAPS_W'(tap_q) + TAPS_W'(1)) == window_taps_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_in)
            REQ_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = grid_addr_i;
              ram_wdata = {data_im_i, data_re_i};
            end
            REQ_READ: begin
              ram_re    = 1'b1;
              ram_raddr = grid_addr_i;
            end
            REQ_FWD, REQ_ADJ: begin
              ram_re     = fast_ok;
              wrap_start = !fast_ok;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        ram_re    = wrap_done;
        ram_raddr = wrap_rem;
      end
      S_READ:  ctrl.mul = 1'b1;
      S_ACC: begin
        ctrl.acc = 1'b1;
        ram_we   = (req_q == REQ_ADJ);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request payload, held for the life of the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_in;
      node_re_q <= data_re_i;
      node_im_q <= data_im_i;
      weight_q  <= weight_i;
      tap_q     <= tap_index_i;
      idx_q     <= fast_idx;
    end else if (state_q == S_MOD && wrap_done) begin
      idx_q <= wrap_rem;
    end
  end

  // ---------------- grid memory ----------------
  wwgs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- arithmetic ----------------
  wwgs_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .grid_re_i   ($signed(ram_rdata[DATA_W-1:0])),
    .grid_im_i   ($signed(ram_rdata[RAM_W-1:DATA_W])),
    .node_re_i   (node_re_q),
    .node_im_i   (node_im_q),
    .weight_i    (weight_q),
    .wb_re_o     (wb_re),
    .wb_im_o     (wb_im),
    .res_valid_o (result_valid_o),
    .res_re_o    (result_re_o),
    .res_im_o    (result_im_o),
    .res_kind_o  (result_kind_o)
  );

`ifndef SYNTH
  // a result only follows the read or accumulate step
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == S_READ || $past(state_q) == S_ACC))
    else $error("result strobe without a read or accumulate step");

  // the remainder unit finishes only while the sequencer waits for it
  a_wrap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_done |-> state_q == S_MOD)
    else $error("wrap remainder done outside wrap state");

  // a grid write request completes at its accepting edge
  a_write_1cyc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_in == REQ_WRITE) |=> !busy_o)
    else $error("grid write left the unit busy");

  // memory write only for a write request or an adjoint write-back
  a_ram_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_IDLE && accept) || (state_q == S_ACC && req_q == REQ_ADJ)))
    else $error("unexpected grid memory write");
`endif

endmodule

`default_nettype wire
